// ===== src/hso_pkg.sv =====
// Package for the hydration shell orientation block: item types, function
// and error codes, register indexes and a lane helper.
// No dependencies; every other file of the block but hso_fifo imports it.
package hso_pkg;

  localparam int REG_W = 19;
  localparam int COUNT_W = 13;
  localparam int OBIN_MAX_W = 10;

  localparam logic [2:0] FUNC_FRAME = 3'd0;
  localparam logic [2:0] FUNC_PAIR = 3'd1;
  localparam logic [2:0] FUNC_MOLBIN = 3'd2;
  localparam logic [2:0] FUNC_RD_ORIENT = 3'd3;
  localparam logic [2:0] FUNC_RD_COORD = 3'd4;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_ZERO_LEN = 2'd1;
  localparam logic [1:0] ERR_COORD_RANGE = 2'd2;

  localparam logic [1:0] REG_BOX_X = 2'd0;
  localparam logic [1:0] REG_BOX_Y = 2'd1;
  localparam logic [1:0] REG_BOX_Z = 2'd2;
  localparam logic [1:0] REG_SHELL = 2'd3;

  localparam logic [COUNT_W-1:0] COORD_MAX = 13'd8191;
  localparam logic [48:0] MIN_R2_X100 = 49'd37748736;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  mol_index;
    logic [11:0] water_index;
    logic [6:0]  bin_select;
    logic [59:0] solute_xyz;
    logic [59:0] oxygen_xyz;
    logic [59:0] hydrogen1_xyz;
    logic [59:0] hydrogen2_xyz;
  } in_item_t;

  typedef struct packed {
    logic               in_shell;
    logic               newly_counted;
    logic signed [15:0] cos_value;
    logic [6:0]         orient_bin;
    logic               bin_counted;
    logic [31:0]        count_value;
    logic [1:0]         error_code;
  } out_item_t;

  typedef struct packed {
    logic [2:0]            func;
    logic [7:0]            mol_index;
    logic [11:0]           water_index;
    logic [6:0]            bin_select;
    logic                  in_shell;
    logic [15:0]           cos_value;
    logic [OBIN_MAX_W-1:0] obin;
    logic                  bin_ok;
    logic [1:0]            err;
  } op_t;

  typedef struct packed {
    logic [REG_W-1:0] box_x;
    logic [REG_W-1:0] box_y;
    logic [REG_W-1:0] box_z;
    logic [REG_W-1:0] shell_radius;
  } cfg_t;

  function automatic logic signed [19:0] lane(input logic [59:0] w, input int k);
    return $signed(w[20*k +: 20]);
  endfunction

endpackage

// ===== src/hso_fifo.sv =====
// Small first-in first-out queue of packed words.
// Used between the front and back parts and on the result side.
module hso_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== src/hso_front.sv =====
// Front part: accepts items, computes folded distances, the shell test,
// and the dipole cosine with an iterative root and divider.
// Depends on hso_pkg.
module hso_front import hso_pkg::*; #(
  parameter int ORIENT_BINS = 100
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  in_item_t in_item,
  input  logic     in_valid,
  output logic     in_ready,
  output op_t      op,
  output logic     op_valid,
  input  logic     op_ready
);
  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_FOLD = 4'd1;
  localparam logic [3:0] F_SQ = 4'd2;
  localparam logic [3:0] F_TEST = 4'd3;
  localparam logic [3:0] F_SQRT = 4'd4;
  localparam logic [3:0] F_MUL = 4'd5;
  localparam logic [3:0] F_CHK = 4'd6;
  localparam logic [3:0] F_DIV = 4'd7;
  localparam logic [3:0] F_FIN = 4'd8;
  localparam logic [3:0] F_DONE = 4'd9;
  localparam logic [10:0] OB = 11'(ORIENT_BINS);

  logic [3:0] state;
  in_item_t item;
  logic [3:0] k;
  logic [21:0] dmag;
  logic [43:0] s1, s2, s3;
  logic [43:0] rem1, rem2, res1, res2, bitv;
  logic [43:0] den;
  logic [44:0] mag;
  logic neg, ovf;
  logic [57:0] dvd;
  logic [58:0] dsh;
  logic [15:0] q;
  logic [3:0] dcnt;
  logic in_shell, bin_ok;
  logic [15:0] cos_r;
  logic [OBIN_MAX_W-1:0] obin;
  logic [1:0] err;

  logic signed [20:0] sp [3];
  logic signed [20:0] ox [3];
  logic signed [20:0] mp [3];
  logic [1:0] pair, ax;
  logic signed [20:0] pa, pb;
  logic [19:0] box2;
  logic signed [21:0] diff;
  logic [21:0] absd, fold;
  logic signed [22:0] alt;
  logic [22:0] alt_mag;
  logic [43:0] prod;
  logic [37:0] rsq;
  logic shell_hit;
  logic [43:0] t1, t2;
  logic signed [45:0] nsum;
  logic signed [15:0] cval;
  logic [14:0] u;
  logic [25:0] bprod;
  logic [10:0] bidx;
  logic cin;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sp[a] = {lane(item.solute_xyz, a), 1'b0};
      ox[a] = {lane(item.oxygen_xyz, a), 1'b0};
      mp[a] = 21'(lane(item.hydrogen1_xyz, a)) + 21'(lane(item.hydrogen2_xyz, a));
    end
    if (k < 4'd3) begin
      pair = 2'd0;
    end else if (k < 4'd6) begin
      pair = 2'd1;
    end else begin
      pair = 2'd2;
    end
    ax = 2'(k - 4'(pair) * 4'd3);
    case (pair)
      2'd0: begin
        pa = sp[ax];
        pb = ox[ax];
      end
      2'd1: begin
        pa = ox[ax];
        pb = mp[ax];
      end
      default: begin
        pa = sp[ax];
        pb = mp[ax];
      end
    endcase
    case (ax)
      2'd0: box2 = {cfg.box_x, 1'b0};
      2'd1: box2 = {cfg.box_y, 1'b0};
      default: box2 = {cfg.box_z, 1'b0};
    endcase
    diff = 22'(pa) - 22'(pb);
    absd = diff[21] ? 22'(-diff) : 22'(diff);
    alt = $signed({3'b0, box2}) - $signed({1'b0, absd});
    alt_mag = alt[22] ? 23'(-alt) : 23'(alt);
    fold = ({absd, 1'b0} > {3'b0, box2}) ? alt_mag[21:0] : absd;
    prod = dmag * dmag;
    rsq = 38'(cfg.shell_radius) * 38'(cfg.shell_radius);
    shell_hit = (s1 <= 44'({rsq, 2'b0}))
             && ((49'({s1, 4'b0}) + 49'({s1, 3'b0}) + 49'(s1)) > MIN_R2_X100);
    t1 = res1 + bitv;
    t2 = res2 + bitv;
    nsum = $signed({2'b0, s1}) + $signed({2'b0, s2}) - $signed({2'b0, s3});
    if (neg) begin
      cval = (ovf || q > 16'd32768) ? 16'sh8000 : 16'(-{1'b0, q});
    end else begin
      cval = (ovf || q > 16'd32767) ? 16'sh7fff : $signed(q);
    end
    cin = (cval > -16'sd16384) && (cval < 16'sd16384);
    u = 15'(cval + 16'sd16384);
    bprod = 26'(u) * 26'(OB);
    bidx = bprod[25:15];
  end

  assign in_ready = (state == F_IDLE);
  assign op_valid = (state == F_DONE);
  always_comb begin
    op.func = item.func;
    op.mol_index = item.mol_index;
    op.water_index = item.water_index;
    op.bin_select = item.bin_select;
    op.in_shell = in_shell;
    op.cos_value = cos_r;
    op.obin = obin;
    op.bin_ok = bin_ok;
    op.err = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            k <= '0;
            s1 <= '0;
            s2 <= '0;
            s3 <= '0;
            in_shell <= 1'b0;
            bin_ok <= 1'b0;
            cos_r <= '0;
            obin <= '0;
            err <= ERR_NONE;
            state <= (in_item.func == FUNC_PAIR) ? F_FOLD : F_DONE;
          end
        end
        F_FOLD: begin
          dmag <= fold;
          state <= F_SQ;
        end
        F_SQ: begin
          case (pair)
            2'd0: s1 <= s1 + prod;
            2'd1: s2 <= s2 + prod;
            default: s3 <= s3 + prod;
          endcase
          if (k == 4'd8) begin
            state <= F_TEST;
          end else begin
            k <= k + 1'b1;
            state <= F_FOLD;
          end
        end
        F_TEST: begin
          if (shell_hit) begin
            in_shell <= 1'b1;
            rem1 <= s1;
            rem2 <= s2;
            res1 <= '0;
            res2 <= '0;
            bitv <= 44'd1 << 42;
            state <= F_SQRT;
          end else begin
            state <= F_DONE;
          end
        end
        F_SQRT: begin
          if (rem1 >= t1) begin
            rem1 <= rem1 - t1;
            res1 <= (res1 >> 1) + bitv;
          end else begin
            res1 <= res1 >> 1;
          end
          if (rem2 >= t2) begin
            rem2 <= rem2 - t2;
            res2 <= (res2 >> 1) + bitv;
          end else begin
            res2 <= res2 >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == 44'd1) begin
            state <= F_MUL;
          end
        end
        F_MUL: begin
          den <= res1[21:0] * res2[21:0];
          neg <= nsum[45];
          mag <= nsum[45] ? 45'(-nsum) : 45'(nsum);
          state <= F_CHK;
        end
        F_CHK: begin
          if (den == '0) begin
            err <= ERR_ZERO_LEN;
            state <= F_DONE;
          end else begin
            ovf <= ({2'b0, mag} >= {den, 3'b0});
            dvd <= {mag, 13'b0};
            dsh <= {den, 15'b0};
            q <= '0;
            dcnt <= '0;
            state <= ({2'b0, mag} >= {den, 3'b0}) ? F_FIN : F_DIV;
          end
        end
        F_DIV: begin
          if ({1'b0, dvd} >= dsh) begin
            dvd <= dvd - dsh[57:0];
            q <= {q[14:0], 1'b1};
          end else begin
            q <= {q[14:0], 1'b0};
          end
          dsh <= dsh >> 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 4'd15) begin
            state <= F_FIN;
          end
        end
        F_FIN: begin
          cos_r <= cval;
          if (cin && bidx < OB) begin
            bin_ok <= 1'b1;
            obin <= OBIN_MAX_W'(bidx);
          end
          state <= F_DONE;
        end
        F_DONE: begin
          if (op_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// ===== src/hso_back.sv =====
// Back part: carries out classified items against the water marks, the
// coordination counts and both histograms, and clears them when needed.
// Depends on hso_pkg.
module hso_back import hso_pkg::*; #(
  parameter int ORIENT_BINS = 100,
  parameter int COORD_BINS = 10,
  parameter int MOLECULES = 256,
  parameter int WATERS = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  op_t       op,
  input  logic      op_valid,
  output logic      op_ready,
  output out_item_t res,
  output logic      res_valid,
  input  logic      res_ready,
  output logic      init_busy
);
  localparam int OB_W = $clog2(ORIENT_BINS);
  localparam int CB_W = $clog2(COORD_BINS);
  localparam int MOL_W = (MOLECULES > 1) ? $clog2(MOLECULES) : 1;
  localparam int WAT_W = (WATERS > 1) ? $clog2(WATERS) : 1;
  localparam int SW_A = (WATERS > MOLECULES) ? WATERS : MOLECULES;
  localparam int SW_B = (ORIENT_BINS > COORD_BINS) ? ORIENT_BINS : COORD_BINS;
  localparam int SW_N = (SW_A > SW_B) ? SW_A : SW_B;
  localparam int SW_W = $clog2(SW_N + 1);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RD1 = 3'd1;
  localparam logic [2:0] B_EXEC = 3'd2;
  localparam logic [2:0] B_SWEEP = 3'd3;

  logic [2:0] state;
  op_t cur;
  logic [SW_W-1:0] idx;

  logic wf_mem [WATERS];
  logic [COUNT_W-1:0] mol_mem [MOLECULES];
  logic [31:0] or_mem [ORIENT_BINS];
  logic [31:0] co_mem [COORD_BINS];

  logic [WAT_W-1:0] wf_a;
  logic [MOL_W-1:0] mol_a;
  logic [OB_W-1:0] or_a;
  logic [CB_W-1:0] co_a;
  logic wf_we, wf_wd, wf_rd;
  logic mol_we;
  logic [COUNT_W-1:0] mol_wd, mol_rd;
  logic or_we, co_we;
  logic [31:0] or_wd, co_wd, or_rd, co_rd;
  logic mol_ok, wat_ok, in_sweep;

  assign op_ready = (state == B_IDLE) && res_ready;
  assign mol_ok = (32'(cur.mol_index) < MOLECULES);
  assign wat_ok = (32'(cur.water_index) < WATERS);
  assign in_sweep = (state == B_SWEEP);

  always_comb begin
    if (in_sweep) begin
      wf_a = WAT_W'(idx);
      mol_a = MOL_W'(idx);
      or_a = OB_W'(idx);
      co_a = CB_W'(idx);
    end else if (state == B_IDLE) begin
      wf_a = WAT_W'(op.water_index);
      mol_a = MOL_W'(op.mol_index);
      or_a = (op.func == FUNC_PAIR) ? OB_W'(op.obin) : OB_W'(op.bin_select);
      co_a = CB_W'(op.bin_select);
    end else begin
      wf_a = WAT_W'(cur.water_index);
      mol_a = MOL_W'(cur.mol_index);
      or_a = (cur.func == FUNC_PAIR) ? OB_W'(cur.obin) : OB_W'(cur.bin_select);
      co_a = (cur.func == FUNC_MOLBIN) ? CB_W'(mol_rd) : CB_W'(cur.bin_select);
    end
  end

  always_comb begin
    wf_we = 1'b0;
    wf_wd = 1'b1;
    mol_we = 1'b0;
    mol_wd = '0;
    or_we = 1'b0;
    or_wd = '0;
    co_we = 1'b0;
    co_wd = '0;
    res = '0;
    res_valid = 1'b0;
    if (in_sweep) begin
      wf_we = (32'(idx) < WATERS);
      mol_we = (32'(idx) < MOLECULES);
      or_we = init_busy && (32'(idx) < ORIENT_BINS);
      co_we = init_busy && (32'(idx) < COORD_BINS);
    end else if (state == B_EXEC) begin
      res_valid = 1'b1;
      case (cur.func)
        FUNC_PAIR: begin
          res.in_shell = cur.in_shell;
          res.cos_value = $signed(cur.cos_value);
          res.error_code = cur.err;
          if (cur.in_shell && mol_ok && wat_ok && wf_rd) begin
            wf_we = 1'b1;
            wf_wd = 1'b0;
            mol_we = 1'b1;
            mol_wd = (mol_rd < COORD_MAX) ? mol_rd + 1'b1 : mol_rd;
            res.newly_counted = 1'b1;
          end
          if (cur.bin_ok) begin
            or_we = 1'b1;
            or_wd = or_rd + 1'b1;
            res.orient_bin = cur.obin[6:0];
            res.bin_counted = 1'b1;
          end
        end
        FUNC_MOLBIN: begin
          if (mol_ok) begin
            res.count_value = 32'(mol_rd);
            if (32'(mol_rd) < COORD_BINS) begin
              co_we = 1'b1;
              co_wd = co_rd + 1'b1;
            end else begin
              res.error_code = ERR_COORD_RANGE;
            end
          end
        end
        FUNC_RD_ORIENT: begin
          if (32'(cur.bin_select) < ORIENT_BINS) begin
            res.count_value = or_rd;
          end
        end
        FUNC_RD_COORD: begin
          if (32'(cur.bin_select) < COORD_BINS) begin
            res.count_value = co_rd;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wf_we) begin
      wf_mem[wf_a] <= wf_wd;
    end
    wf_rd <= wf_mem[wf_a];
    if (mol_we) begin
      mol_mem[mol_a] <= mol_wd;
    end
    mol_rd <= mol_mem[mol_a];
    if (or_we) begin
      or_mem[or_a] <= or_wd;
    end
    or_rd <= or_mem[or_a];
    if (co_we) begin
      co_mem[co_a] <= co_wd;
    end
    co_rd <= co_mem[co_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_SWEEP;
      init_busy <= 1'b1;
      idx <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (op_valid && res_ready) begin
            cur <= op;
            idx <= '0;
            state <= (op.func == FUNC_FRAME) ? B_SWEEP : B_RD1;
          end
        end
        B_RD1: state <= B_EXEC;
        B_EXEC: state <= B_IDLE;
        B_SWEEP: begin
          if (idx == SW_W'(SW_N - 1)) begin
            init_busy <= 1'b0;
            state <= init_busy ? B_IDLE : B_EXEC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== src/hydration_shell_orientation.sv =====
// Top level of the hydration shell orientation block: register port,
// front part, item queue, back part and result queue.
// Depends on hso_pkg, hso_front, hso_fifo and hso_back.
//
// Items enter on cmd with push/full and leave on result with empty/pop.
// Registers box_x, box_y, box_z and shell_radius sit at byte addresses
// 0, 4, 8 and 12 of the APB port; write them only while the block is idle.
// A pair test folds nine squares on one multiplier in the front part, then
// takes a 22-step root and a 16-step divider; a pair outside the shell skips
// the root and divider, and other items pass the front without computing.
// The back part takes one item at a time through a read and an execute state
// for its memory read-modify-write. A new frame clears the water marks and
// coordination counts in the back part, sweeping max(WATERS, MOLECULES,
// ORIENT_BINS, COORD_BINS) addresses, 4096 by default, while the front keeps
// working into the queue. After reset the same sweep also clears both
// histograms, and full stays high until it ends. When the receiver stalls,
// two results wait in the result queue, four items in the middle queue and
// one in the front part, and full then stays high.
module hydration_shell_orientation import hso_pkg::*; #(
  parameter int ORIENT_BINS = 100,
  parameter int COORD_BINS = 10,
  parameter int MOLECULES = 256,
  parameter int WATERS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  in_item_t    cmd,
  input  logic        push,
  output logic        full,
  output out_item_t   result,
  output logic        empty,
  input  logic        pop
);
  cfg_t cfg;
  logic front_ready, init_busy;
  op_t f_op, b_op;
  logic f_valid, mid_full, mid_empty, b_ready;
  logic [$bits(op_t)-1:0] mid_rdata;
  out_item_t b_res;
  logic b_valid, out_full;
  logic [$bits(out_item_t)-1:0] out_rdata;

  assign pready = 1'b1;
  assign full = !front_ready || init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x <= 19'd40960;
      cfg.box_y <= 19'd40960;
      cfg.box_z <= 19'd40960;
      cfg.shell_radius <= 19'd1434;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_BOX_X: cfg.box_x <= pwdata[REG_W-1:0];
        REG_BOX_Y: cfg.box_y <= pwdata[REG_W-1:0];
        REG_BOX_Z: cfg.box_z <= pwdata[REG_W-1:0];
        REG_SHELL: cfg.shell_radius <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BOX_X: prdata = 32'(cfg.box_x);
      REG_BOX_Y: prdata = 32'(cfg.box_y);
      REG_BOX_Z: prdata = 32'(cfg.box_z);
      REG_SHELL: prdata = 32'(cfg.shell_radius);
      default: prdata = '0;
    endcase
  end

  hso_front #(.ORIENT_BINS(ORIENT_BINS)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_item(cmd), .in_valid(push && !init_busy), .in_ready(front_ready),
    .op(f_op), .op_valid(f_valid), .op_ready(!mid_full)
  );

  hso_fifo #(.WIDTH($bits(op_t)), .DEPTH(4)) u_mid (
    .clk(clk), .rst(rst), .push(f_valid), .wdata(f_op), .full(mid_full),
    .pop(b_ready), .rdata(mid_rdata), .empty(mid_empty)
  );

  assign b_op = op_t'(mid_rdata);

  hso_back #(
    .ORIENT_BINS(ORIENT_BINS), .COORD_BINS(COORD_BINS),
    .MOLECULES(MOLECULES), .WATERS(WATERS)
  ) u_back (
    .clk(clk), .rst(rst), .op(b_op), .op_valid(!mid_empty), .op_ready(b_ready),
    .res(b_res), .res_valid(b_valid), .res_ready(!out_full), .init_busy(init_busy)
  );

  hso_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(2)) u_out (
    .clk(clk), .rst(rst), .push(b_valid), .wdata(b_res), .full(out_full),
    .pop(pop), .rdata(out_rdata), .empty(empty)
  );

  assign result = out_item_t'(out_rdata);
endmodule

// ===== src/hso_checker.sv =====
// Port-level checks for the hydration shell orientation block, and the
// bind that attaches them to the top level. Depends on hso_pkg.
module hso_checker import hso_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      pready,
  input logic      full,
  input out_item_t result,
  input logic      empty,
  input logic      pop
);
  a_reset_state: assert property (@(posedge clk) rst |=> empty && full)
    else $error("queues not idle after reset");
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");
  a_bin_needs_hit: assert property (@(posedge clk) disable iff (rst)
      !empty && result.bin_counted |-> result.in_shell && result.error_code == ERR_NONE)
    else $error("binned item without a clean shell hit");
  a_miss_is_quiet: assert property (@(posedge clk) disable iff (rst)
      !empty && !result.in_shell |-> !result.newly_counted && result.cos_value == 16'sd0)
    else $error("item outside the shell carries pair results");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
      !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");
endmodule

bind hydration_shell_orientation hso_checker u_hso_checker (.*);

// ===== sim/tb_top.sv =====
// Testbench for the hydration shell orientation block: drives items through
// the push/full queue, predicts each result in place and checks every field.
// Depends on hso_pkg and the hydration_shell_orientation top level.
module tb_top;
  import hso_pkg::*;

  localparam int N_OBINS = 100;
  localparam int N_CBINS = 10;
  localparam int N_MOLS = 256;
  localparam int N_WATERS = 4096;
  localparam logic [REG_W-1:0] REG_ALL = 19'h7FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  in_item_t cmd = '0;
  logic push = 1'b0;
  logic full;
  out_item_t result;
  logic empty;
  logic pop = 1'b0;

  hydration_shell_orientation i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd(cmd), .push(push), .full(full), .result(result), .empty(empty),
    .pop(pop)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cfg_t shell_cfg;
  bit water_avail [N_WATERS];
  logic [COUNT_W-1:0] mol_count [N_MOLS];
  logic [31:0] orient_hist [N_OBINS];
  logic [31:0] coord_hist [N_CBINS];
  out_item_t expected_q [$];
  int errors = 0;
  int hold_cycles = 0;
  bit quiet = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint lane_val(input logic [59:0] w, input int k);
    logic signed [19:0] s;
    s = w[20*k +: 20];
    return longint'(s);
  endfunction

  function automatic longint folded_sq(input longint a, input longint b, input longint box2);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    if (2 * d > box2) d = box2 - d;
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic longint sep_sq(input longint a [3], input longint b [3]);
    return folded_sq(a[0], b[0], 2 * longint'(shell_cfg.box_x))
         + folded_sq(a[1], b[1], 2 * longint'(shell_cfg.box_y))
         + folded_sq(a[2], b[2], 2 * longint'(shell_cfg.box_z));
  endfunction

  function automatic void clear_frame();
    foreach (water_avail[i]) water_avail[i] = 1'b1;
    foreach (mol_count[i]) mol_count[i] = '0;
  endfunction

  function automatic out_item_t predict_shell(input in_item_t it);
    out_item_t r;
    longint sp [3], op [3], mp [3];
    longint s1, s2, s3, n, den, q, c, lim, b;
    r = '0;
    case (it.func)
      FUNC_FRAME: clear_frame();
      FUNC_PAIR: begin
        for (int k = 0; k < 3; k++) begin
          sp[k] = 2 * lane_val(it.solute_xyz, k);
          op[k] = 2 * lane_val(it.oxygen_xyz, k);
          mp[k] = lane_val(it.hydrogen1_xyz, k) + lane_val(it.hydrogen2_xyz, k);
        end
        s1 = sep_sq(sp, op);
        lim = 4 * longint'(shell_cfg.shell_radius) * longint'(shell_cfg.shell_radius);
        if (s1 <= lim && 25 * s1 > longint'(MIN_R2_X100)) begin
          s2 = sep_sq(op, mp);
          s3 = sep_sq(sp, mp);
          den = longint'(int_sqrt(s1) * int_sqrt(s2));
          r.in_shell = 1'b1;
          if (water_avail[it.water_index]) begin
            water_avail[it.water_index] = 1'b0;
            if (mol_count[it.mol_index] < COORD_MAX) mol_count[it.mol_index]++;
            r.newly_counted = 1'b1;
          end
          if (den == 0) begin
            r.error_code = ERR_ZERO_LEN;
          end else begin
            n = s1 + s2 - s3;
            q = ((n < 0) ? -n : n) * 8192 / den;
            if (n < 0) c = (q > 32768) ? -32768 : -q;
            else c = (q > 32767) ? 32767 : q;
            r.cos_value = c[15:0];
            if (c > -16384 && c < 16384) begin
              b = ((c + 16384) * N_OBINS) >>> 15;
              orient_hist[b]++;
              r.orient_bin = b[6:0];
              r.bin_counted = 1'b1;
            end
          end
        end
      end
      FUNC_MOLBIN: begin
        r.count_value = 32'(mol_count[it.mol_index]);
        if (mol_count[it.mol_index] < N_CBINS) coord_hist[mol_count[it.mol_index]]++;
        else r.error_code = ERR_COORD_RANGE;
      end
      FUNC_RD_ORIENT: if (it.bin_select < N_OBINS) r.count_value = orient_hist[it.bin_select];
      FUNC_RD_COORD: if (it.bin_select < N_CBINS) r.count_value = coord_hist[it.bin_select];
      default: ;
    endcase
    return r;
  endfunction

  // Push stays high after acceptance; the next item or drain() drives it.
  task automatic send_item(input in_item_t it, input bit gaps);
    @(negedge clk);
    if (gaps && $urandom_range(99) < 9) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    cmd <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    expected_q.push_back(predict_shell(it));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    push <= 1'b0;
    while (expected_q.size() != 0 && guard < 400000) begin
      @(negedge clk);
      guard++;
    end
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BOX_X: shell_cfg.box_x = v;
      REG_BOX_Y: shell_cfg.box_y = v;
      REG_BOX_Z: shell_cfg.box_z = v;
      default: shell_cfg.shell_radius = v;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [REG_W-1:0] bx, input logic [REG_W-1:0] by,
                            input logic [REG_W-1:0] bz, input logic [REG_W-1:0] rad);
    write_reg(REG_BOX_X, bx);
    write_reg(REG_BOX_Y, by);
    write_reg(REG_BOX_Z, bz);
    write_reg(REG_SHELL, rad);
  endtask

  function automatic logic [59:0] pack_xyz(input int x, input int y, input int z);
    return {z[19:0], y[19:0], x[19:0]};
  endfunction

  function automatic in_item_t make_op(input logic [2:0] f);
    in_item_t it;
    it = '0;
    it.func = f;
    it.mol_index = 8'($urandom_range(N_MOLS - 1));
    it.water_index = 12'($urandom_range(N_WATERS - 1));
    it.bin_select = 7'($urandom_range(127));
    return it;
  endfunction

  // A water placed within spread of the solute on each axis, so that some pairs land in the shell.
  function automatic in_item_t make_pair(input int spread);
    in_item_t it;
    int sx, sy, sz, ox, oy, oz;
    it = make_op(FUNC_PAIR);
    it.mol_index = 8'($urandom_range(15));
    it.water_index = 12'($urandom_range(63));
    sx = $urandom_range(0, 1 << 20) - (1 << 19);
    sy = $urandom_range(0, 1 << 20) - (1 << 19);
    sz = $urandom_range(0, 1 << 20) - (1 << 19);
    ox = sx + $urandom_range(0, 2 * spread) - spread;
    oy = sy + $urandom_range(0, 2 * spread) - spread;
    oz = sz + $urandom_range(0, 2 * spread) - spread;
    it.solute_xyz = pack_xyz(sx, sy, sz);
    it.oxygen_xyz = pack_xyz(ox, oy, oz);
    it.hydrogen1_xyz = pack_xyz(ox + $urandom_range(0, 800) - 400,
                                oy + $urandom_range(0, 800) - 400,
                                oz + $urandom_range(0, 800) - 400);
    it.hydrogen2_xyz = pack_xyz(ox + $urandom_range(0, 800) - 400,
                                oy + $urandom_range(0, 800) - 400,
                                oz + $urandom_range(0, 800) - 400);
    return it;
  endfunction

  function automatic in_item_t make_noise();
    in_item_t it;
    it = make_op(3'($urandom_range(7)));
    it.solute_xyz = 60'({$urandom, $urandom});
    it.oxygen_xyz = 60'({$urandom, $urandom});
    it.hydrogen1_xyz = 60'({$urandom, $urandom});
    it.hydrogen2_xyz = 60'({$urandom, $urandom});
    return it;
  endfunction

  task automatic test_directed();
    in_item_t it;
    it = make_pair(0);
    it.func = FUNC_PAIR;
    it.solute_xyz = pack_xyz(0, 0, 0);
    it.oxygen_xyz = pack_xyz(1000, 0, 0);
    it.hydrogen1_xyz = pack_xyz(1400, 300, 0);
    it.hydrogen2_xyz = pack_xyz(1400, -300, 0);
    it.water_index = 0;
    it.mol_index = 0;
    send_item(it, 0);
    send_item(it, 0);
    it.hydrogen1_xyz = pack_xyz(600, 300, 0);
    it.hydrogen2_xyz = pack_xyz(600, -300, 0);
    send_item(it, 0);
    it.hydrogen1_xyz = pack_xyz(1000, 300, 0);
    it.hydrogen2_xyz = pack_xyz(1000, -300, 0);
    it.water_index = 12'hFFF;
    it.mol_index = 8'hFF;
    send_item(it, 0);
    it.hydrogen1_xyz = pack_xyz(1000, 0, 0);
    it.hydrogen2_xyz = pack_xyz(1000, 0, 0);
    send_item(it, 0);
    it.oxygen_xyz = pack_xyz(100, 0, 0);
    send_item(it, 0);
    it.oxygen_xyz = pack_xyz(5000, 0, 0);
    send_item(it, 0);
    it.solute_xyz = {60{1'b1}};
    it.oxygen_xyz = {3{20'h80000}};
    it.hydrogen1_xyz = {3{20'h7FFFF}};
    it.hydrogen2_xyz = {3{20'h80000}};
    send_item(it, 0);
    for (int f = 2; f <= 7; f++) begin
      it = make_op(3'(f));
      it.mol_index = (f == 2) ? 8'd0 : 8'hFF;
      it.bin_select = (f == 5) ? 7'd127 : 7'd0;
      send_item(it, 0);
    end
    for (int b = 0; b < 3; b++) begin
      it = make_op(FUNC_RD_ORIENT);
      it.bin_select = (b == 0) ? 7'd99 : (b == 1) ? 7'd100 : 7'd50;
      send_item(it, 0);
      it.func = FUNC_RD_COORD;
      it.bin_select = (b == 0) ? 7'd9 : (b == 1) ? 7'd10 : 7'd1;
      send_item(it, 0);
    end
    send_item(make_op(FUNC_FRAME), 0);
    drain();
  endtask

  task automatic test_count_overflow();
    in_item_t it;
    for (int w = 0; w < 12; w++) begin
      it = make_pair(0);
      it.solute_xyz = pack_xyz(0, 0, 0);
      it.oxygen_xyz = pack_xyz(0, 1000, 0);
      it.hydrogen1_xyz = pack_xyz(300, 1400, 0);
      it.hydrogen2_xyz = pack_xyz(-300, 1400, 0);
      it.mol_index = 8'd3;
      it.water_index = 12'(100 + w);
      send_item(it, 0);
    end
    it = make_op(FUNC_MOLBIN);
    it.mol_index = 8'd3;
    send_item(it, 0);
    send_item(make_op(FUNC_FRAME), 0);
    drain();
  endtask

  task automatic test_random(input int count, input int spread, input bit gaps);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 70) send_item(make_pair(spread), gaps);
      else if (r < 80) send_item(make_op(FUNC_MOLBIN), gaps);
      else if (r < 88) send_item(make_op(3'($urandom_range(3, 4))), gaps);
      else if (r < 90) send_item(make_op(FUNC_FRAME), gaps);
      else send_item(make_noise(), gaps);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(20, 3000, 0);
    drain();
  endtask

  task automatic test_box_extremes();
    set_config(19'd0, 19'd0, 19'd0, REG_ALL);
    test_random(40, 6000, 1);
    drain();
    set_config(REG_ALL, REG_ALL, REG_ALL, 19'd0);
    test_random(20, 6000, 1);
    drain();
    set_config(19'd3000, 19'd5000, 19'd2500, 19'd2600);
    test_random(80, 3000, 1);
    drain();
    set_config(19'd40960, 19'd40960, 19'd40960, 19'd1434);
  endtask

  // Receiver: random stalls unless quiet, plus a long hold-off when the stimulus asks.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 64'(result), 64'(0));
      end else begin
        want = expected_q.pop_front();
        if (result.in_shell !== want.in_shell)
          report("in_shell", 64'(result.in_shell), 64'(want.in_shell));
        if (result.newly_counted !== want.newly_counted)
          report("newly_counted", 64'(result.newly_counted), 64'(want.newly_counted));
        if (result.cos_value !== want.cos_value)
          report("cos_value", 64'(result.cos_value), 64'(want.cos_value));
        if (result.orient_bin !== want.orient_bin)
          report("orient_bin", 64'(result.orient_bin), 64'(want.orient_bin));
        if (result.bin_counted !== want.bin_counted)
          report("bin_counted", 64'(result.bin_counted), 64'(want.bin_counted));
        if (result.count_value !== want.count_value)
          report("count_value", 64'(result.count_value), 64'(want.count_value));
        if (result.error_code !== want.error_code)
          report("error_code", 64'(result.error_code), 64'(want.error_code));
      end
    end
  end

  initial begin
    shell_cfg = '{box_x: 19'd40960, box_y: 19'd40960, box_z: 19'd40960,
                  shell_radius: 19'd1434};
    clear_frame();
    foreach (orient_hist[i]) orient_hist[i] = '0;
    foreach (coord_hist[i]) coord_hist[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_count_overflow();
    test_box_extremes();
    test_backpressure();
    quiet = 1'b1;
    test_random(60, 3000, 0);
    drain();
    quiet = 1'b0;
    test_random(260, 3000, 1);
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule
